// ----- rtl/core/gse_pkg.sv -----
// Shared types and constants for the Golomb stream encoder.
// Used by every module under rtl/core; depends on nothing else.
package gse_pkg;

   // Field and register widths
   localparam int VALUE_BITS    = 16;
   localparam int DIVISOR_BITS  = 17;
   localparam int CODE_BITS_W   = 5;
   localparam int WORD_BITS     = 32;
   localparam int MAX_QUOTIENT  = 32;

   // Quotient register: one bit beyond the bound so an oversize quotient shows
   localparam int QUOT_BITS     = $clog2(MAX_QUOTIENT + 1);
   localparam int STEP_BITS     = $clog2(QUOT_BITS);

   // Pending stream bits and their count
   localparam int PEND_BITS     = WORD_BITS - 1;
   localparam int CNT_BITS      = $clog2(WORD_BITS);
   localparam int ACC_BITS      = PEND_BITS + WORD_BITS;

   // Dividend is value + 2M, one bit wider than the larger term
   localparam int DIFF_BITS     = ((VALUE_BITS > DIVISOR_BITS + 1) ?
                                   VALUE_BITS : DIVISOR_BITS + 1) + 1;
   localparam int SHM_BITS      = DIVISOR_BITS + QUOT_BITS;
   localparam int CMP_BITS      = (SHM_BITS > DIFF_BITS) ? SHM_BITS : DIFF_BITS;

   // Queue between front and back
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes and reset values
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DIVISOR   = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CODE_BITS = 1'd1;
   localparam logic [DIVISOR_BITS-1:0]   DIVISOR_RESET   = 17'd12;
   localparam logic [CODE_BITS_W-1:0]    CODE_BITS_RESET = 5'd4;

   // Live configuration handed to the front
   typedef struct packed {
      logic [DIVISOR_BITS-1:0] divisor;
      logic [CODE_BITS_W-1:0]  code_bits;
   } cfg_type;

   // One classified item as it waits for the packer
   typedef struct packed {
      logic [PEND_BITS-1:0]   rem_bits;
      logic [QUOT_BITS-1:0]   quot;
      logic [CODE_BITS_W-1:0] code_bits;
      logic                   reject;
      logic                   last;
   } code_entry_type;

endpackage

// ----- rtl/core/gse_front.sv -----
// Front end: accepts a value, finds its Golomb quotient and remainder.
// Depends on gse_pkg; feeds gse_queue.
module gse_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [gse_pkg::VALUE_BITS-1:0] req_value,
   input  logic                          req_last_value,
   input  gse_pkg::cfg_type              cfg,
   output logic                          push_valid,
   output gse_pkg::code_entry_type       push_entry,
   input  logic                          queue_full
);
   import gse_pkg::*;

   localparam logic [2:0] F_IDLE  = 3'd0;
   localparam logic [2:0] F_PREP  = 3'd1;
   localparam logic [2:0] F_RANGE = 3'd2;
   localparam logic [2:0] F_DIV   = 3'd3;
   localparam logic [2:0] F_PUSH  = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [VALUE_BITS-1:0]   value_ff, value_in;
   logic                    last_ff, last_in;
   logic [DIVISOR_BITS-1:0] divisor_ff, divisor_in;
   logic [CODE_BITS_W-1:0]  code_bits_ff, code_bits_in;
   logic [DIFF_BITS-1:0]    rem_ff, rem_in;
   logic [QUOT_BITS-1:0]    quot_ff, quot_in;
   logic [STEP_BITS-1:0]    step_ff, step_in;
   logic                    over_ff, over_in;

   logic [DIFF_BITS-1:0]    pos;
   logic [DIFF_BITS-1:0]    neg;
   logic                    neg_fits;
   logic [CMP_BITS-1:0]     rem_wide;
   logic [CMP_BITS-1:0]     shifted_m;
   logic [CMP_BITS-1:0]     range_lim;
   logic                    div_ge;
   logic [WORD_BITS-1:0]    rem_wrap;

   // Datapath terms
   assign pos       = DIFF_BITS'(value_ff) + (DIFF_BITS'(divisor_ff) << 1);
   assign neg_fits  = int'(code_bits_ff) < DIFF_BITS;
   assign neg       = DIFF_BITS'(1) << code_bits_ff;
   assign rem_wide  = CMP_BITS'(rem_ff);
   assign shifted_m = CMP_BITS'(divisor_ff) << step_ff;
   assign range_lim = CMP_BITS'(divisor_ff) << QUOT_BITS;
   assign div_ge    = rem_wide >= shifted_m;

   // Sequencer: latch, offset, range check, one quotient bit a cycle, hand over
   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      divisor_in   = divisor_ff;
      code_bits_in = code_bits_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      step_in      = step_ff;
      over_in      = over_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               value_in     = req_value;
               last_in      = req_last_value;
               // a zero divisor acts as one
               divisor_in   = (cfg.divisor == '0) ? DIVISOR_BITS'(1) : cfg.divisor;
               code_bits_in = cfg.code_bits;
               state_in     = F_PREP;
            end
         end
         F_PREP: begin
            // negative dividend gives quotient zero
            if (neg_fits && pos >= neg) begin
               rem_in = pos - neg;
            end else begin
               rem_in = '0;
            end
            quot_in  = '0;
            state_in = F_RANGE;
         end
         F_RANGE: begin
            over_in  = rem_wide >= range_lim;
            step_in  = STEP_BITS'(QUOT_BITS - 1);
            state_in = F_DIV;
         end
         F_DIV: begin
            if (div_ge) begin
               rem_in = rem_ff - shifted_m[DIFF_BITS-1:0];
            end
            quot_in = {quot_ff[QUOT_BITS-2:0], div_ge};
            if (step_ff == '0) begin
               state_in = F_PUSH;
            end else begin
               step_in = step_ff - STEP_BITS'(1);
            end
         end
         F_PUSH: begin
            if (!queue_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // Remainder field: (r - M) keeps the low b bits of v - (q-1)M
   assign rem_wrap = WORD_BITS'(rem_ff) - WORD_BITS'(divisor_ff);

   // b + q stays below 64 for every register value, so only q is bounded
   always_comb begin
      push_entry.reject    = over_ff || (quot_ff > QUOT_BITS'(MAX_QUOTIENT));
      push_entry.quot      = quot_ff;
      push_entry.code_bits = code_bits_ff;
      push_entry.last      = last_ff;
      push_entry.rem_bits  = (quot_ff == '0) ? PEND_BITS'(value_ff)
                                             : rem_wrap[PEND_BITS-1:0];
   end

   assign push_valid = state_ff == F_PUSH;
   assign req_stall  = state_ff != F_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      last_ff      <= last_in;
      divisor_ff   <= divisor_in;
      code_bits_ff <= code_bits_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      step_ff      <= step_in;
      over_ff      <= over_in;
   end

endmodule

// ----- rtl/core/gse_queue.sv -----
// Two-entry queue of classified items between front and packer.
// Depends on gse_pkg.
module gse_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  gse_pkg::code_entry_type push_entry,
   output logic                    full,
   input  logic                    pop,
   output gse_pkg::code_entry_type head_entry,
   output logic                    empty
);
   import gse_pkg::*;

   code_entry_type       entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full       = count_ff == QCNT_BITS'(QUEUE_DEPTH);
   assign empty      = count_ff == '0;
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && !empty;
   assign head_entry = entries_ff[rd_ptr_ff];

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                               : wr_ptr_ff + QPTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                               : rd_ptr_ff + QPTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/core/gse_packer.sv -----
// Back end: appends codewords to the bit stream and sends 32-bit words.
// Depends on gse_pkg; drains gse_queue, drives the result channel.
module gse_packer (
   input  logic                         clock,
   input  logic                         reset,
   input  gse_pkg::code_entry_type      head_entry,
   input  logic                         empty,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [gse_pkg::WORD_BITS-1:0] rsp_packed_word,
   output logic                         rsp_last_word,
   output logic                         rsp_rejected
);
   import gse_pkg::*;

   // Phases of one item: remainder field, quotient field, flush
   localparam logic [1:0] P_CODE  = 2'd0;
   localparam logic [1:0] P_QUOT  = 2'd1;
   localparam logic [1:0] P_FLUSH = 2'd2;

   logic [1:0]           phase_ff, phase_in;
   logic [PEND_BITS-1:0] pend_ff, pend_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 out_valid_ff, out_valid_in;
   logic [WORD_BITS-1:0] out_word_ff, out_word_in;
   logic                 out_last_ff, out_last_in;
   logic                 out_rej_ff, out_rej_in;

   logic                 out_free;
   logic                 step;
   logic                 load;
   logic [QUOT_BITS-1:0] n;
   logic [WORD_BITS-1:0] bits;
   logic [WORD_BITS:0]   n_mask;
   logic [ACC_BITS-1:0]  acc;
   logic [ACC_BITS-1:0]  acc_shift;
   logic [QUOT_BITS-1:0] sum;
   logic                 emit;
   logic [CNT_BITS-1:0]  new_cnt;
   logic [PEND_BITS:0]   cnt_mask;
   logic [PEND_BITS-1:0] new_pend;
   logic [WORD_BITS-1:0] flush_word;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign step     = !empty && out_free;

   // Append up to 32 bits to the pending bits; a full word drops out on top
   always_comb begin
      if (phase_ff == P_QUOT) begin
         n    = head_entry.quot;
         bits = WORD_BITS'(1);
      end else begin
         n    = QUOT_BITS'(head_entry.code_bits);
         bits = WORD_BITS'(head_entry.rem_bits);
      end
   end

   assign n_mask    = ((WORD_BITS + 1)'(1) << n) - (WORD_BITS + 1)'(1);
   assign acc       = (ACC_BITS'(pend_ff) << n) | ACC_BITS'(bits & n_mask[WORD_BITS-1:0]);
   assign sum       = QUOT_BITS'(cnt_ff) + n;
   assign emit      = sum >= QUOT_BITS'(WORD_BITS);
   assign new_cnt   = sum[CNT_BITS-1:0];
   assign acc_shift = acc >> new_cnt;
   assign cnt_mask  = ((PEND_BITS + 1)'(1) << new_cnt) - (PEND_BITS + 1)'(1);
   assign new_pend  = acc[PEND_BITS-1:0] & cnt_mask[PEND_BITS-1:0];

   // Flush: leftover bits left-aligned, zero padded
   assign flush_word = WORD_BITS'(pend_ff)
                       << (QUOT_BITS'(WORD_BITS) - QUOT_BITS'(cnt_ff));

   // Phase control and result selection
   always_comb begin
      phase_in    = phase_ff;
      pend_in     = pend_ff;
      cnt_in      = cnt_ff;
      pop         = 1'b0;
      load        = 1'b0;
      out_word_in = out_word_ff;
      out_last_in = out_last_ff;
      out_rej_in  = out_rej_ff;
      if (step) begin
         case (phase_ff)
            P_CODE: begin
               if (head_entry.reject) begin
                  // skipped value: one zero word, stream untouched
                  load        = 1'b1;
                  out_word_in = '0;
                  out_rej_in  = 1'b1;
                  out_last_in = head_entry.last && (cnt_ff == '0);
                  if (head_entry.last && cnt_ff != '0) begin
                     phase_in = P_FLUSH;
                  end else begin
                     pop = 1'b1;
                  end
               end else begin
                  load        = emit;
                  out_word_in = acc_shift[WORD_BITS-1:0];
                  out_rej_in  = 1'b0;
                  out_last_in = head_entry.last && (head_entry.quot == '0) &&
                                (new_cnt == '0);
                  pend_in     = new_pend;
                  cnt_in      = new_cnt;
                  if (head_entry.quot != '0) begin
                     phase_in = P_QUOT;
                  end else if (head_entry.last && new_cnt != '0) begin
                     phase_in = P_FLUSH;
                  end else begin
                     pop = 1'b1;
                  end
               end
            end
            P_QUOT: begin
               // q-1 zeros and a closing one
               load        = emit;
               out_word_in = acc_shift[WORD_BITS-1:0];
               out_rej_in  = 1'b0;
               out_last_in = head_entry.last && (new_cnt == '0);
               pend_in     = new_pend;
               cnt_in      = new_cnt;
               if (head_entry.last && new_cnt != '0) begin
                  phase_in = P_FLUSH;
               end else begin
                  phase_in = P_CODE;
                  pop      = 1'b1;
               end
            end
            P_FLUSH: begin
               load        = 1'b1;
               out_word_in = flush_word;
               out_rej_in  = 1'b0;
               out_last_in = 1'b1;
               pend_in     = '0;
               cnt_in      = '0;
               phase_in    = P_CODE;
               pop         = 1'b1;
            end
            default: begin
               phase_in = P_CODE;
            end
         endcase
      end
   end

   // Output register: refilled as soon as the waiting item is taken
   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= P_CODE;
         pend_ff      <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pend_ff      <= pend_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_word_ff <= out_word_in;
         out_last_ff <= out_last_in;
         out_rej_ff  <= out_rej_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_packed_word = out_word_ff;
   assign rsp_last_word   = out_last_ff;
   assign rsp_rejected    = out_rej_ff;

endmodule

// ----- rtl/core/golomb_stream_encoder_core.sv -----
// Golomb stream encoder top level: configuration registers, front, queue, packer.
// Depends on gse_pkg, gse_front, gse_queue and gse_packer.
//
// Each value goes through the front end in order: it is taken in, the offset is
// applied, the range is checked, a bit-per-cycle restoring divider forms the
// quotient, and the item is handed to a two-entry queue once it has room. No new
// value is taken until that hand-over is done.
// The packer behind the queue handles the remainder field, then the quotient
// field when q is nonzero and the flush of a last value, and sends at most one
// 32-bit word a cycle through its output register while rsp_stall is low, so it
// keeps pace and rarely pushes back. Values whose quotient exceeds 32 are not
// coded: they give a single zero word flagged as rejected. Divisor and code
// width are sampled as each value is taken, and may be written only while the
// block is idle.
module golomb_stream_encoder_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [gse_pkg::VALUE_BITS-1:0]    req_value,
   input  logic                              req_last_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [gse_pkg::WORD_BITS-1:0]     rsp_packed_word,
   output logic                              rsp_last_word,
   output logic                              rsp_rejected,
   input  logic                              csr_write_en,
   input  logic [gse_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [gse_pkg::DIVISOR_BITS-1:0]  csr_wdata
);
   import gse_pkg::*;

   logic [DIVISOR_BITS-1:0] divisor_ff, divisor_in;
   logic [CODE_BITS_W-1:0]  code_bits_ff, code_bits_in;
   cfg_type                 cfg;
   logic                    push_valid;
   code_entry_type          push_entry;
   logic                    queue_full;
   logic                    queue_pop;
   code_entry_type          head_entry;
   logic                    queue_empty;

   // Configuration registers
   always_comb begin
      divisor_in   = divisor_ff;
      code_bits_in = code_bits_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_DIVISOR:   divisor_in   = csr_wdata;
            REG_CODE_BITS: code_bits_in = csr_wdata[CODE_BITS_W-1:0];
            default: begin
               divisor_in = divisor_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff   <= DIVISOR_RESET;
         code_bits_ff <= CODE_BITS_RESET;
      end else begin
         divisor_ff   <= divisor_in;
         code_bits_ff <= code_bits_in;
      end
   end

   assign cfg.divisor   = divisor_ff;
   assign cfg.code_bits = code_bits_ff;

   gse_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .req_last_value (req_last_value),
      .cfg            (cfg),
      .push_valid     (push_valid),
      .push_entry     (push_entry),
      .queue_full     (queue_full)
   );

   gse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .head_entry (head_entry),
      .empty      (queue_empty)
   );

   gse_packer u_packer (
      .clock           (clock),
      .reset           (reset),
      .head_entry      (head_entry),
      .empty           (queue_empty),
      .pop             (queue_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_packed_word (rsp_packed_word),
      .rsp_last_word   (rsp_last_word),
      .rsp_rejected    (rsp_rejected)
   );

endmodule

// ----- rtl/core/gse_checker.sv -----
// Port-level checks for the Golomb stream encoder, bound to the top level.
// Depends on gse_pkg and golomb_stream_encoder_core.
module gse_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [gse_pkg::WORD_BITS-1:0] rsp_packed_word,
   input logic                          rsp_last_word,
   input logic                          rsp_rejected
);
   import gse_pkg::*;

   // A stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_packed_word) &&
                                 $stable(rsp_last_word) && $stable(rsp_rejected))
      else $error("stalled result item changed");

   // A skipped value carries an all-zero word
   a_rej_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_packed_word == '0)
      else $error("rejected item with nonzero word");

   // Out of reset: nothing pending on the output, front ready to take an item
   a_reset_state: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind golomb_stream_encoder_core gse_checker u_gse_checker (.*);

// ----- dv/golomb_stream_encoder_core_test.sv -----
// Self-checking test of golomb_stream_encoder_core: directed and random values
// under several divisor and code-width settings, with idling on both channels.
// Depends on gse_pkg and the RTL under rtl/core; reads no files.
`timescale 1ns / 1ps

module golomb_stream_encoder_core_test;

   localparam int DRAIN_CYCLES = 48;    // generous allowance for the front end to finish
   localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
   localparam int QUIET_LIMIT  = 3000;  // cycles with no handshake before giving up

   // One output word as the encoder should send it
   typedef struct packed {
      logic [gse_pkg::WORD_BITS-1:0] packed_word;
      logic                          last_word;
      logic                          rejected;
   } coded_word_type;

   // Bit-accurate copy of the encoder plus the words still owed by the block
   class golomb_scoreboard;
      bit [gse_pkg::DIVISOR_BITS-1:0] divisor = gse_pkg::DIVISOR_RESET;
      bit [gse_pkg::CODE_BITS_W-1:0]  code_bits = gse_pkg::CODE_BITS_RESET;
      bit [gse_pkg::PEND_BITS-1:0]    stream_bits;
      int unsigned                    fill;
      coded_word_type                 words_due[$];
      int unsigned errors, values_seen, words_seen, rejects_seen, finals_seen;

      function void push_word(input logic [31:0] word, input logic rej);
         coded_word_type w;
         w.packed_word = word;
         w.last_word   = 1'b0;
         w.rejected    = rej;
         words_due.push_back(w);
      endfunction

      // Append n (0..32) bits to the stream, cutting a word off at 32
      function void shift_in(input longint unsigned bits, input int unsigned n);
         bit [63:0]   acc;
         int unsigned cnt;
         if (n == 0) return;
         acc = (64'(stream_bits) << n) | (bits & ((64'd1 << n) - 64'd1));
         cnt = fill + n;
         if (cnt >= 32) begin
            cnt -= 32;
            push_word(32'(acc >> cnt), 1'b0);
         end
         stream_bits = 31'(acc & ((64'd1 << cnt) - 64'd1));
         fill = cnt;
      endfunction

      // Work out the words caused by one accepted value
      function void encode_value(input logic [15:0] value, input logic last);
         longint unsigned v, m, pos, neg, q, r;
         int unsigned     b, base;
         values_seen++;
         base = words_due.size();
         v = value;
         m = (divisor == 0) ? 64'd1 : 64'(divisor);
         b = code_bits;
         pos = v + 64'd2 * m;
         neg = 64'd1 << b;
         q = 0;
         if (pos >= neg) q = (pos - neg) / m;
         if (q > gse_pkg::MAX_QUOTIENT || 64'(b) + q > 2 * gse_pkg::WORD_BITS) begin
            push_word('0, 1'b1);
         end else begin
            // remainder wraps when the registers disagree; only b bits go out
            r = (q == 0) ? v : v - (q - 64'd1) * m;
            shift_in(r, b);
            if (q > 0) begin
               shift_in(0, 32'(q - 64'd1));
               shift_in(1, 1);
            end
         end
         if (last) begin
            if (fill > 0) begin
               push_word(32'(64'(stream_bits) << (32 - fill)), 1'b0);
               stream_bits = '0;
               fill = 0;
            end
            if (words_due.size() > base) words_due[words_due.size() - 1].last_word = 1'b1;
         end
      endfunction

      task report_mismatch(input string what);
         $display("%0t ns  mismatch: %s", $realtime, what);
         errors++;
      endtask

      task check_word(input logic [31:0] word, input logic last_w, input logic rej);
         coded_word_type due;
         words_seen++;
         if (rej === 1'b1) rejects_seen++;
         if (last_w === 1'b1) finals_seen++;
         if (words_due.size() == 0) begin
            report_mismatch($sformatf("word %h arrived with nothing due", word));
            return;
         end
         due = words_due.pop_front();
         if (word !== due.packed_word)
            report_mismatch($sformatf("word %0d packed_word %h, want %h",
                                      words_seen, word, due.packed_word));
         if (last_w !== due.last_word)
            report_mismatch($sformatf("word %0d last_word %b, want %b",
                                      words_seen, last_w, due.last_word));
         if (rej !== due.rejected)
            report_mismatch($sformatf("word %0d rejected %b, want %b",
                                      words_seen, rej, due.rejected));
      endtask
   endclass

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic [gse_pkg::VALUE_BITS-1:0]      req_value;
   logic                                req_last_value;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic [gse_pkg::WORD_BITS-1:0]       rsp_packed_word;
   logic                                rsp_last_word;
   logic                                rsp_rejected;
   logic                                csr_write_en;
   logic [gse_pkg::CSR_INDEX_BITS-1:0]  csr_index;
   logic [gse_pkg::DIVISOR_BITS-1:0]    csr_wdata;

   golomb_scoreboard sb;
   bit               hold_off_req;
   int unsigned      holds_done;
   int unsigned      settings_run;
   int unsigned      quiet_cycles;

   golomb_stream_encoder_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value       (req_value),
      .req_last_value  (req_last_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_packed_word (rsp_packed_word),
      .rsp_last_word   (rsp_last_word),
      .rsp_rejected    (rsp_rejected),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Handshake monitors: note each accepted value, check each accepted word
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.encode_value(req_value, req_last_value);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_word(rsp_packed_word, rsp_last_word, rsp_rejected);
   end

   // Watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d words still due",
                     QUIET_LIMIT, sb.words_due.size());
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Receiver: stall mode picked at random at regular intervals, plus an occasional long hold-off
   initial begin
      int unsigned mode, hold_left, tick;
      mode = 0;
      hold_left = 0;
      tick = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_left = HOLD_CYCLES;
            hold_off_req = 1'b0;
            holds_done++;
         end
         if (tick % 48 == 0) mode = $urandom_range(0, 3);
         tick++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ((tick % 7) < 4);
               default: rsp_stall <= ($urandom_range(0, 1) == 0);
            endcase
         end
      end
   end

   // Offer one item and return at the edge where it is taken
   task automatic offer(input logic [15:0] value, input logic last);
      req_valid      <= 1'b1;
      req_value      <= value;
      req_last_value <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic idle_cycles(input int unsigned n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Wait until every due word is in, then let any word-less item finish
   task automatic await_drain();
      req_valid <= 1'b0;
      while (sb.words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [gse_pkg::DIVISOR_BITS-1:0] divisor,
                             input logic [gse_pkg::CODE_BITS_W-1:0] width);
      csr_write_en <= 1'b1;
      csr_index    <= gse_pkg::REG_DIVISOR;
      csr_wdata    <= divisor;
      @(posedge clock);
      csr_index    <= gse_pkg::REG_CODE_BITS;
      csr_wdata    <= {{(gse_pkg::DIVISOR_BITS - gse_pkg::CODE_BITS_W){1'b0}}, width};
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.divisor   = divisor;
      sb.code_bits = width;
      settings_run++;
   endtask

   // Mostly values whose quotient sits near or under the bound
   function automatic logic [15:0] pick_value(input longint unsigned m_eff);
      longint unsigned span;
      int unsigned     roll;
      span = 34 * m_eff;
      if (span > 65535) span = 65535;
      roll = $urandom_range(0, 19);
      if (roll < 14) return 16'($urandom_range(0, 32'(span)));
      if (roll < 17) return 16'($urandom);
      case ($urandom_range(0, 4))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'(span);
         3: return 16'(m_eff - 1);
         default: return 16'(m_eff);
      endcase
   endfunction

   // One register setting: drain, write both registers, then random items
   task automatic run_phase(input logic [gse_pkg::DIVISOR_BITS-1:0] divisor,
                            input logic [gse_pkg::CODE_BITS_W-1:0] width,
                            input int unsigned count, input bit squeeze);
      longint unsigned m_eff;
      int unsigned     burst_left;
      bit              no_gaps;
      await_drain();
      set_config(divisor, width);
      m_eff = (divisor == 0) ? 1 : divisor;
      no_gaps = squeeze || ($urandom_range(0, 2) == 0);
      burst_left = $urandom_range(1, 16);
      if (squeeze) hold_off_req = 1'b1;
      for (int i = 0; i < count; i++) begin
         offer(pick_value(m_eff), ($urandom_range(0, 7) == 0));
         if (!no_gaps) begin
            if (burst_left == 0) begin
               idle_cycles($urandom_range(1, 12));
               burst_left = $urandom_range(1, 16);
            end else begin
               burst_left--;
            end
         end
      end
   endtask

   initial begin
      logic [16:0] opening [15];
      sb = new();
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_value      <= '0;
      req_last_value <= 1'b0;
      csr_write_en   <= 1'b0;
      csr_index      <= gse_pkg::REG_DIVISOR;
      csr_wdata      <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset setting M=12, b=4: short and long codes, quotient bound on both
      // sides, rejection with and without a flush, last with nothing pending,
      // and a codeword that ends exactly on a word boundary
      opening = '{{1'b0, 16'd0},     {1'b0, 16'd3},     {1'b0, 16'd4},
                  {1'b0, 16'd15},    {1'b0, 16'd387},   {1'b0, 16'd388},
                  {1'b0, 16'hFFFF},  {1'b1, 16'd395},   {1'b1, 16'd0},
                  {1'b1, 16'hFFFF},  {1'b1, 16'd330},   {1'b0, 16'd1000},
                  {1'b0, 16'd200},   {1'b0, 16'd50},    {1'b1, 16'd7}};
      foreach (opening[i]) offer(opening[i][15:0], opening[i][16]);

      run_phase(17'd12,     5'd4,  25, 1'b0);
      run_phase(17'd2,      5'd1,  35, 1'b0);   // smallest consistent setting
      run_phase(17'd65536,  5'd16, 30, 1'b0);   // largest consistent setting
      run_phase(17'd3,      5'd2,  30, 1'b0);
      run_phase(17'd100,    5'd7,  40, 1'b1);   // receiver holds off, block fills
      run_phase(17'd0,      5'd1,  25, 1'b0);   // zero divisor acts as one
      run_phase(17'd5,      5'd4,  25, 1'b0);   // negative offset
      run_phase(17'd3,      5'd1,  25, 1'b0);   // remainder wider than b
      run_phase(17'h1FFFF,  5'd31, 20, 1'b0);   // all register bits set
      run_phase(17'd1,      5'd0,  25, 1'b0);   // no remainder field
      run_phase(17'd40000,  5'd3,  20, 1'b0);
      run_phase(17'd600,    5'd10, 40, 1'b0);
      await_drain();

      $display("covered %0d values and %0d words (%0d rejected, %0d marked last)",
               sb.values_seen, sb.words_seen, sb.rejects_seen, sb.finals_seen);
      $display("over %0d register settings with %0d long receiver hold-off(s)",
               settings_run, holds_done);
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
